// ===== design/gcfb_pkg.sv =====
// ----------------------------------------------------------------------------
// gcfb_pkg
// Shared constants, types and the round function of the byte-wise GOST CFB
// cipher.
// ----------------------------------------------------------------------------
package gcfb_pkg;

  localparam int unsigned NUM_KEYS    = 8;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned NUM_ROUNDS  = 32;
  localparam int unsigned FWD_ROUNDS  = 24;  // rounds with key order K0..K7
  localparam int unsigned ROT_AMT     = 11;
  localparam int unsigned ADDR_W      = 5;   // 8 registers at 4-byte steps
  localparam int unsigned KIDX_W      = $clog2(NUM_KEYS);
  localparam int unsigned RND_W       = $clog2(NUM_ROUNDS);

  typedef logic [NUM_KEYS-1:0][KEY_W-1:0] key_set_t;

  // CryptoPro-A substitution boxes, box i reads nibble i
  localparam logic [3:0] SBOX [NUM_KEYS][16] = '{
    '{4'd9,  4'd6,  4'd3,  4'd2,  4'd8,  4'd11, 4'd1,  4'd7,
      4'd10, 4'd4,  4'd14, 4'd15, 4'd12, 4'd0,  4'd13, 4'd5},
    '{4'd3,  4'd7,  4'd14, 4'd9,  4'd8,  4'd10, 4'd15, 4'd0,
      4'd5,  4'd2,  4'd6,  4'd12, 4'd11, 4'd4,  4'd13, 4'd1},
    '{4'd14, 4'd4,  4'd6,  4'd2,  4'd11, 4'd3,  4'd13, 4'd8,
      4'd12, 4'd15, 4'd5,  4'd10, 4'd0,  4'd7,  4'd1,  4'd9},
    '{4'd14, 4'd7,  4'd10, 4'd12, 4'd13, 4'd1,  4'd3,  4'd9,
      4'd0,  4'd2,  4'd11, 4'd4,  4'd15, 4'd8,  4'd5,  4'd6},
    '{4'd11, 4'd5,  4'd1,  4'd9,  4'd8,  4'd13, 4'd15, 4'd0,
      4'd14, 4'd4,  4'd2,  4'd3,  4'd12, 4'd7,  4'd10, 4'd6},
    '{4'd3,  4'd10, 4'd13, 4'd12, 4'd1,  4'd2,  4'd0,  4'd11,
      4'd7,  4'd5,  4'd9,  4'd4,  4'd8,  4'd15, 4'd14, 4'd6},
    '{4'd1,  4'd13, 4'd2,  4'd9,  4'd7,  4'd10, 4'd6,  4'd0,
      4'd8,  4'd12, 4'd4,  4'd5,  4'd15, 4'd3,  4'd11, 4'd14},
    '{4'd11, 4'd10, 4'd15, 4'd5,  4'd0,  4'd12, 4'd14, 4'd8,
      4'd6,  4'd2,  4'd3,  4'd9,  4'd1,  4'd7,  4'd13, 4'd4}
  };

  // substitution: output of box i lands at nibble 7-i
  function automatic logic [KEY_W-1:0] sbox_sub(input logic [KEY_W-1:0] s);
    logic [KEY_W-1:0] r;
    r = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      r[4*(NUM_KEYS-1-i) +: 4] = SBOX[i][s[4*i +: 4]];
    end
    return r;
  endfunction

  // add key, substitute, rotate left
  function automatic logic [KEY_W-1:0] round_fn(input logic [KEY_W-1:0] half,
                                                input logic [KEY_W-1:0] kw);
    logic [KEY_W-1:0] s;
    logic [KEY_W-1:0] r;
    s = half + kw;
    r = sbox_sub(s);
    return {r[KEY_W-1-ROT_AMT:0], r[KEY_W-1:KEY_W-ROT_AMT]};
  endfunction

endpackage

// ===== design/gcfb_regs.sv =====
// ----------------------------------------------------------------------------
// gcfb_regs
// APB-style key register file: eight 32-bit key words, reset to zero.
// ----------------------------------------------------------------------------
module gcfb_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gcfb_pkg::ADDR_W-1:0]   paddr,
  input  logic [gcfb_pkg::KEY_W-1:0]    pwdata,
  output logic [gcfb_pkg::KEY_W-1:0]    prdata,
  output logic                          pready,
  output gcfb_pkg::key_set_t            keys
);

  gcfb_pkg::key_set_t               key_r;
  logic [gcfb_pkg::KIDX_W-1:0]      sel;
  logic                             wr_en;

  assign pready = 1'b1;
  assign sel    = paddr[gcfb_pkg::ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (wr_en) begin
      key_r[sel] <= pwdata;
    end
  end

  assign prdata = key_r[sel];
  assign keys   = key_r;

endmodule

// ===== design/gcfb_round.sv =====
// ----------------------------------------------------------------------------
// gcfb_round
// One Feistel round of the block cipher, shared by all 32 rounds. Picks the
// key word from the round number.
// ----------------------------------------------------------------------------
module gcfb_round (
  input  logic [gcfb_pkg::RND_W-1:0]  rnd,
  input  gcfb_pkg::key_set_t          keys,
  input  logic [gcfb_pkg::KEY_W-1:0]  lo,
  input  logic [gcfb_pkg::KEY_W-1:0]  hi,
  output logic [gcfb_pkg::KEY_W-1:0]  lo_nxt
);

  localparam logic [gcfb_pkg::RND_W-1:0] FWD_LAST =
    gcfb_pkg::RND_W'(gcfb_pkg::FWD_ROUNDS - 1);

  logic [gcfb_pkg::KIDX_W-1:0] kidx;

  // last eight rounds run the key schedule backwards
  assign kidx   = (rnd <= FWD_LAST) ? rnd[gcfb_pkg::KIDX_W-1:0]
                                    : ~rnd[gcfb_pkg::KIDX_W-1:0];
  assign lo_nxt = hi ^ gcfb_pkg::round_fn(lo, keys[kidx]);

endmodule

// ===== design/gost_cfb_byte_cipher.sv =====
// ----------------------------------------------------------------------------
// gost_cfb_byte_cipher
// Byte-wise 64-bit CFB on a GOST 28147-89 block cipher, one round per cycle.
// ----------------------------------------------------------------------------
// channel  direction  handshake           payload
// in       request    in_valid/in_stall   in_cmd, in_data_byte, in_start_req,
//                                         in_sync
// out      result     out_valid/out_stall out_out_byte
// cfg      APB        psel/penable/pready paddr, pwdata, prdata
//
// A byte inside a block is XORed with the stored keystream and its result is
// registered in the out register as it is accepted; the next request is taken
// once that result has left. A start byte or a byte at position 0 first runs
// the 32 rounds through the shared round unit, then posts its result.
// Requests are stalled while rounds run or a result waits in the out register.
// Reset (synchronous, active low) clears keys, blocks and byte position.
// ----------------------------------------------------------------------------
module gost_cfb_byte_cipher (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cmd,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_start_req,
  input  logic [31:0]                   in_sync,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_out_byte,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gcfb_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_ROUND = 1'b1;
  localparam logic [gcfb_pkg::RND_W-1:0] RND_LAST =
    gcfb_pkg::RND_W'(gcfb_pkg::NUM_ROUNDS - 1);

  gcfb_pkg::key_set_t keys;

  logic        state_r, state_nxt;
  logic [gcfb_pkg::RND_W-1:0] rnd_r, rnd_nxt;
  logic [31:0] lo_r, lo_nxt, hi_r, hi_nxt, round_out;
  logic [63:0] ks_r, ks_nxt, fb_r, fb_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic        cmd_r;
  logic [7:0]  data_r;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;

  logic        in_acc, out_acc, last_rnd;
  logic        emit;
  logic        emit_cmd;
  logic [7:0]  emit_data, emit_ks, emit_res;
  logic [2:0]  emit_pos;
  logic [63:0] emit_ks_blk;

  gcfb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .keys    (keys)
  );

  gcfb_round u_round (
    .rnd    (rnd_r),
    .keys   (keys),
    .lo     (lo_r),
    .hi     (hi_r),
    .lo_nxt (round_out)
  );

  assign in_stall = (state_r != ST_IDLE) || out_valid_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign last_rnd = (state_r == ST_ROUND) && (rnd_r == RND_LAST);

  // result byte: straight from a mid-block request, or after the last round
  always_comb begin
    emit        = 1'b0;
    emit_cmd    = in_cmd;
    emit_data   = in_data_byte;
    emit_pos    = pos_r;
    emit_ks_blk = ks_r;
    if (last_rnd) begin
      emit        = 1'b1;
      emit_cmd    = cmd_r;
      emit_data   = data_r;
      emit_pos    = '0;
      emit_ks_blk = {round_out, lo_r};
    end else if (in_acc && !in_start_req && (pos_r != '0)) begin
      emit = 1'b1;
    end
    emit_ks  = emit_ks_blk[{emit_pos, 3'b000} +: 8];
    emit_res = emit_data ^ emit_ks;
  end

  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    ks_nxt        = ks_r;
    fb_nxt        = fb_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_acc;
    out_byte_nxt  = out_byte_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          rnd_nxt = '0;
          if (in_start_req) begin
            lo_nxt    = in_sync;
            hi_nxt    = ~in_sync;
            pos_nxt   = '0;
            state_nxt = ST_ROUND;
          end else if (pos_r == '0) begin
            lo_nxt    = fb_r[31:0];
            hi_nxt    = fb_r[63:32];
            state_nxt = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        lo_nxt  = round_out;
        hi_nxt  = lo_r;
        rnd_nxt = rnd_r + 1'b1;
        if (last_rnd) begin
          ks_nxt    = emit_ks_blk;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (emit) begin
      // decrypt feeds back the incoming ciphertext
      fb_nxt[{emit_pos, 3'b000} +: 8] = emit_cmd ? emit_data : emit_res;
      pos_nxt       = emit_pos + 1'b1;
      out_valid_nxt = 1'b1;
      out_byte_nxt  = emit_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_r       <= '0;
      ks_r        <= '0;
      fb_r        <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      ks_r        <= ks_nxt;
      fb_r        <= fb_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    out_byte_r <= out_byte_nxt;
    if (in_acc) begin
      cmd_r  <= in_cmd;
      data_r <= in_data_byte;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_out_byte = out_byte_r;

  // mid-block request posts its result in the next cycle
  a_mid_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_start_req && (pos_r != '0)) |=> (out_valid && (state_r == ST_IDLE)))
    else $error("mid-block request did not give a result next cycle");

  // no result held while rounds run
  a_round_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> !out_valid_r)
    else $error("result pending during rounds");

  // last round ends the block and posts byte 0's result
  a_round_done: assert property (@(posedge clk) disable iff (!rst_n)
    last_rnd |=> ((state_r == ST_IDLE) && out_valid_r && (pos_r == 3'd1)))
    else $error("block encryption did not finish properly");

endmodule
